// File: src/crc16fac_pkg.sv
// shared types, constants and the byte-wise crc update for the crc16 frame block
package crc16fac_pkg;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_START_VALUE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_APPEND_MODE = 1'b1;
	localparam int unsigned CFG_DATA_W  = 16;

	// crc constants
	localparam logic [15:0] CRC_RESET_VALUE = 16'hFFFF;
	localparam logic [15:0] CRC_PARITY_MASK = 16'hC001;

	// job queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// one job handed from front to back
	typedef struct packed {
		logic [7:0]  data;
		logic [15:0] crc;
		logic        match;
		logic        last_flag;
		logic        trailer;
	} job_t;

	// output sequencing of the back part
	typedef enum logic [1:0] {
		PH_ITEM,
		PH_CRC_LO,
		PH_CRC_HI
	} back_phase_t;

	// reflected crc-16 (0xa001) update by one byte, via parity of the combined byte
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0]  v;
		logic [15:0] r;
		v = b ^ crc[7:0];
		r = {8'h00, crc[15:8]};
		if (^v) begin
			r = r ^ CRC_PARITY_MASK;
		end
		r = r ^ {2'b00, v, 6'b000000} ^ {1'b0, v, 7'b0000000};
		return r;
	endfunction

endpackage

// File: src/crc16fac_front.sv
// front part: takes bytes, runs the crc and frame tracking, issues jobs
module crc16fac_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          data_byte,
	input  logic                                frame_end,
	input  logic                                cfg_we,
	input  logic [crc16fac_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [crc16fac_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                                q_full,
	output logic                                push,
	output crc16fac_pkg::job_t                  push_job
);

	logic [15:0] start_q;
	logic        append_q;
	logic [15:0] crc_q;
	logic [15:0] held_q;
	logic [1:0]  held_cnt_q;

	logic        accept;
	logic [15:0] crc_in;
	logic [15:0] crc_next;
	logic [15:0] held_next;
	logic [1:0]  cnt_next;
	logic        match;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// crc of incoming byte for append, of the byte leaving the hold window for check
	assign crc_in = crc16fac_pkg::crc_update(crc_q, append_q ? data_byte : held_q[15:8]);

	// check mode window: the two newest bytes stay out of the crc
	always_comb begin
		held_next = {held_q[7:0], data_byte};
		if (held_cnt_q == 2'd2) begin
			crc_next = crc_in;
			cnt_next = held_cnt_q;
		end else begin
			crc_next = crc_q;
			cnt_next = held_cnt_q + 2'd1;
		end
		match = (cnt_next == 2'd2) && ({held_next[7:0], held_next[15:8]} == crc_next);
	end

	// job towards the back part
	always_comb begin
		push = accept && (append_q || frame_end);
		if (append_q) begin
			push_job.data      = data_byte;
			push_job.crc       = crc_in;
			push_job.match     = 1'b0;
			push_job.last_flag = frame_end;
			push_job.trailer   = frame_end;
		end else begin
			push_job.data      = 8'h00;
			push_job.crc       = crc_next;
			push_job.match     = match;
			push_job.last_flag = 1'b1;
			push_job.trailer   = 1'b0;
		end
	end

	// configuration and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= crc16fac_pkg::CRC_RESET_VALUE;
			append_q   <= 1'b0;
			crc_q      <= crc16fac_pkg::CRC_RESET_VALUE;
			held_q     <= 16'h0000;
			held_cnt_q <= 2'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				crc16fac_pkg::REG_START_VALUE: begin
					start_q <= cfg_data;
					crc_q   <= cfg_data;
				end
				crc16fac_pkg::REG_APPEND_MODE: begin
					append_q <= cfg_data[0];
					crc_q    <= start_q;
				end
				default: begin
					crc_q <= start_q;
				end
			endcase
			held_q     <= 16'h0000;
			held_cnt_q <= 2'd0;
		end else if (accept) begin
			if (frame_end) begin
				crc_q      <= start_q;
				held_q     <= 16'h0000;
				held_cnt_q <= 2'd0;
			end else if (append_q) begin
				crc_q <= crc_in;
			end else begin
				crc_q      <= crc_next;
				held_q     <= held_next;
				held_cnt_q <= cnt_next;
			end
		end
	end

endmodule

// File: src/crc16fac_queue.sv
// short job queue between the front and back parts
module crc16fac_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  crc16fac_pkg::job_t push_job,
	input  logic               pop,
	output crc16fac_pkg::job_t head_job,
	output logic               empty,
	output logic               full
);

	crc16fac_pkg::job_t                   mem_q [crc16fac_pkg::QUEUE_DEPTH];
	logic [crc16fac_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [crc16fac_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [crc16fac_pkg::QUEUE_CNT_W-1:0] count_q;
	logic                                 do_push;
	logic                                 do_pop;

	localparam logic [crc16fac_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
		crc16fac_pkg::QUEUE_PTR_W'(crc16fac_pkg::QUEUE_DEPTH - 1);
	localparam logic [crc16fac_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
		crc16fac_pkg::QUEUE_CNT_W'(crc16fac_pkg::QUEUE_DEPTH);

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_FULL);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/crc16fac_back.sv
// back part: turns jobs into result transfers through an output register
module crc16fac_back (
	input  logic               clk,
	input  logic               arst_n,
	input  crc16fac_pkg::job_t head_job,
	input  logic               q_empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic [15:0]        crc_value,
	output logic               crc_match,
	output logic               run_last
);

	crc16fac_pkg::back_phase_t phase_q;
	crc16fac_pkg::back_phase_t phase_d;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic [15:0] crc_value_q;
	logic        crc_match_q;
	logic        run_last_q;

	logic        take;
	logic        load;
	logic [7:0]  byte_d;
	logic        match_d;
	logic        last_d;

	assign take = !out_valid_q || out_ready;

	// phase sequencing and next result
	always_comb begin
		phase_d = phase_q;
		pop     = 1'b0;
		load    = 1'b0;
		byte_d  = head_job.data;
		match_d = 1'b0;
		last_d  = 1'b0;
		unique case (phase_q)
			crc16fac_pkg::PH_ITEM: begin
				match_d = head_job.match;
				last_d  = head_job.last_flag && !head_job.trailer;
				if (take && !q_empty) begin
					load = 1'b1;
					if (head_job.trailer) begin
						phase_d = crc16fac_pkg::PH_CRC_LO;
					end else begin
						pop = 1'b1;
					end
				end
			end
			crc16fac_pkg::PH_CRC_LO: begin
				byte_d = head_job.crc[7:0];
				if (take) begin
					load    = 1'b1;
					phase_d = crc16fac_pkg::PH_CRC_HI;
				end
			end
			crc16fac_pkg::PH_CRC_HI: begin
				byte_d = head_job.crc[15:8];
				last_d = 1'b1;
				if (take) begin
					load    = 1'b1;
					pop     = 1'b1;
					phase_d = crc16fac_pkg::PH_ITEM;
				end
			end
			default: begin
				phase_d = crc16fac_pkg::PH_ITEM;
			end
		endcase
	end

	// phase register and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= crc16fac_pkg::PH_ITEM;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= byte_d;
			crc_value_q <= head_job.crc;
			crc_match_q <= match_d;
			run_last_q  <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign crc_value = crc_value_q;
	assign crc_match = crc_match_q;
	assign run_last  = run_last_q;

endmodule

// File: src/crc16_frame_append_check_top.sv
// top level of the crc-16 frame appender and checker
//
// Input channel: one frame byte per transfer (data_byte, frame_end marks the
// last byte), valid/ready. Output channel: result transfers of out_byte,
// crc_value, crc_match, run_last, valid/ready. Configuration: cfg_we writes
// cfg_data into register cfg_index (0 start value, 1 append mode).
// Append mode: every byte is passed through with the running crc; the last
// byte is followed by the crc low byte, then the high byte with run_last.
// Check mode: the last two bytes of a frame are held back, and the last
// byte gives one result with the crc of the bytes before them and the match.
// A result passes through the job queue and then the output register of the
// back part before it is offered. The input takes one byte per cycle while
// the job queue is not full; a frame's last byte in append mode gives three
// results, which leave through the single output register of the back part.
// A four-entry job queue lets the input keep going while the output stalls;
// when it fills, in_ready drops until the receiver takes results again.
// Reset clears the queue and output valid, loads start value 0xffff and
// selects check mode.
module crc16_frame_append_check_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           data_byte,
	input  logic                                 frame_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [7:0]                           out_byte,
	output logic [15:0]                          crc_value,
	output logic                                 crc_match,
	output logic                                 run_last,
	input  logic                                 cfg_we,
	input  logic [crc16fac_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [crc16fac_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic               q_full;
	logic               q_empty;
	logic               push;
	logic               pop;
	crc16fac_pkg::job_t push_job;
	crc16fac_pkg::job_t head_job;

	// byte intake and crc
	crc16fac_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.frame_end (frame_end),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	// job queue
	crc16fac_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.empty    (q_empty),
		.full     (q_full)
	);

	// result sequencing
	crc16fac_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_job  (head_job),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.crc_value (crc_value),
		.crc_match (crc_match),
		.run_last  (run_last)
	);

endmodule

// File: src/crc16fac_checker.sv
// port-level checks for the crc-16 frame block, bound to the top level
module crc16fac_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic [15:0] crc_value,
	input logic        crc_match,
	input logic        run_last
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(crc_value)
			&& $stable(crc_match) && $stable(run_last))
		else $error("result payload changed while stalled");

	// a match is only reported on the final result of a frame
	a_match_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && crc_match |-> run_last)
		else $error("crc_match without run_last");

	// a matching check result carries a zero byte
	a_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && crc_match |-> out_byte == 8'h00)
		else $error("crc_match with non-zero out_byte");

endmodule

bind crc16_frame_append_check_top crc16fac_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.crc_value (crc_value),
	.crc_match (crc_match),
	.run_last  (run_last)
);

// File: tb/crc16_frame_append_check_top_tb.sv
// self-checking testbench for the crc-16 frame appender and checker
module crc16_frame_append_check_top_tb;

	localparam logic MODE_CHECK  = 1'b0;
	localparam logic MODE_APPEND = 1'b1;
	localparam logic [15:0] CRC_POLY_REFLECTED = 16'hA001;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 1000;
	localparam int HOLD_CYCLES   = 80;
	localparam int IDLE_PCT      = 32;

	typedef struct packed {
		logic [7:0]  out_b;
		logic [15:0] crc;
		logic        match;
		logic        last;
	} frame_result_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 in_valid = 1'b0;
	logic                                 in_ready;
	logic [7:0]                           data_byte = 8'h00;
	logic                                 frame_end = 1'b0;
	logic                                 out_valid;
	logic                                 out_ready = 1'b0;
	logic [7:0]                           out_byte;
	logic [15:0]                          crc_value;
	logic                                 crc_match;
	logic                                 run_last;
	logic                                 cfg_we = 1'b0;
	logic [crc16fac_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [crc16fac_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	// predicted block state and configuration
	logic [15:0] cfg_start = crc16fac_pkg::CRC_RESET_VALUE;
	logic        cfg_append = MODE_CHECK;
	logic [15:0] frame_crc = crc16fac_pkg::CRC_RESET_VALUE;
	logic [15:0] held_pair = 16'h0000;
	int          held_cnt = 0;

	frame_byte_t   bytes_to_send[$];
	frame_result_t results_due[$];
	int            fail_count = 0;
	int            quiet_cycles = 0;
	int            hold_left = 0;
	bit            hold_req = 1'b0;
	bit            steady_run = 1'b0;
	bit            in_done = 1'b0;

	crc16_frame_append_check_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.frame_end (frame_end),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.crc_value (crc_value),
		.crc_match (crc_match),
		.run_last  (run_last),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// bit-serial reflected crc-16 over one byte
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY_REFLECTED) : (r >> 1);
		end
		return r;
	endfunction

	function automatic frame_result_t result_of(input logic [7:0] ob, input logic [15:0] crc,
			input logic match, input logic last);
		frame_result_t r;
		r.out_b = ob;
		r.crc   = crc;
		r.match = match;
		r.last  = last;
		return r;
	endfunction

	function automatic bit take_break();
		return !steady_run && ($urandom_range(99) < IDLE_PCT);
	endfunction

	task automatic restart_frame();
		frame_crc = cfg_start;
		held_pair = 16'h0000;
		held_cnt  = 0;
	endtask

	// expected results for one accepted frame byte
	task automatic track_frame_byte(input logic [7:0] b, input logic last);
		logic match;
		if (cfg_append == MODE_APPEND) begin
			frame_crc = crc16_step(frame_crc, b);
			results_due.push_back(result_of(b, frame_crc, 1'b0, 1'b0));
			if (last) begin
				results_due.push_back(result_of(frame_crc[7:0], frame_crc, 1'b0, 1'b0));
				results_due.push_back(result_of(frame_crc[15:8], frame_crc, 1'b0, 1'b1));
				restart_frame();
			end
		end else begin
			// the two newest bytes stay out of the crc until a newer one arrives
			if (held_cnt >= 2) begin
				frame_crc = crc16_step(frame_crc, held_pair[15:8]);
			end else begin
				held_cnt++;
			end
			held_pair = {held_pair[7:0], b};
			if (last) begin
				match = (held_cnt >= 2) && ({held_pair[7:0], held_pair[15:8]} == frame_crc);
				results_due.push_back(result_of(8'h00, frame_crc, match, 1'b1));
				restart_frame();
			end
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic last);
		frame_byte_t fb;
		fb.data = b;
		fb.last = last;
		bytes_to_send.push_back(fb);
	endtask

	// queue a frame, optionally sealed with its crc and optionally spoilt by one bit
	task automatic queue_frame(input logic [7:0] body[$], input bit sealed, input bit spoil);
		logic [15:0] crc;
		int idx;
		crc = cfg_start;
		if (sealed) begin
			foreach (body[i]) begin
				crc = crc16_step(crc, body[i]);
			end
			body.push_back(crc[7:0]);
			body.push_back(crc[15:8]);
		end
		if (spoil) begin
			idx = $urandom_range(body.size() - 1);
			body[idx] = body[idx] ^ (8'h01 << $urandom_range(7));
		end
		foreach (body[i]) begin
			queue_byte(body[i], i == body.size() - 1);
		end
	endtask

	task automatic write_reg(input logic [crc16fac_pkg::CFG_INDEX_W-1:0] idx,
			input logic [crc16fac_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == crc16fac_pkg::REG_START_VALUE) begin
			cfg_start = value;
		end else if (idx == crc16fac_pkg::REG_APPEND_MODE) begin
			cfg_append = value[0];
		end
		restart_frame();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until all bytes are sent and all results seen, then let the pipeline drain
	task automatic wait_idle();
		while (bytes_to_send.size() != 0 || in_valid || results_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// one configuration setting followed by random frames
	task automatic run_phase(input logic [15:0] start, input logic mode, input int goal,
			input bit steady, input bit squeeze);
		logic [7:0] body[$];
		int sent;
		int pick;
		int n;
		write_reg(crc16fac_pkg::REG_START_VALUE, start);
		write_reg(crc16fac_pkg::REG_APPEND_MODE,
			{{(crc16fac_pkg::CFG_DATA_W-1){1'b0}}, mode});
		steady_run = steady;
		sent = 0;
		while (sent < goal) begin
			body.delete();
			pick = $urandom_range(9);
			n = (mode == MODE_APPEND || pick <= 1) ? $urandom_range(1, 6) : $urandom_range(0, 5);
			if (mode == MODE_CHECK && pick == 0) begin
				n = 1;
			end
			repeat (n) body.push_back(8'($urandom));
			if (mode == MODE_APPEND || pick <= 1) begin
				queue_frame(body, 1'b0, 1'b0);
				sent += n;
			end else begin
				queue_frame(body, 1'b1, pick == 2);
				sent += n + 2;
			end
		end
		if (squeeze) begin
			hold_req = 1'b1;
		end
		wait_idle();
		steady_run = 1'b0;
	endtask

	// byte sender: new transfer only after the previous one was taken
	always @(negedge clk) begin : byte_driver
		frame_byte_t nb;
		if (!in_valid || in_done) begin
			in_done = 1'b0;
			if (arst_n && bytes_to_send.size() != 0 && !take_break()) begin
				nb = bytes_to_send.pop_front();
				in_valid  <= 1'b1;
				data_byte <= nb.data;
				frame_end <= nb.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver with random stalls and one long hold-off on request
	always @(negedge clk) begin : result_sink
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && !take_break();
		end
	end

	// predict on accepted bytes, check accepted results
	always @(posedge clk) begin : edge_sample
		frame_result_t want;
		if (arst_n && in_valid && in_ready) begin
			track_frame_byte(data_byte, frame_end);
			in_done = 1'b1;
		end
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$display("%0t: unexpected result out_byte %h crc_value %h crc_match %b run_last %b",
					$time, out_byte, crc_value, crc_match, run_last);
				fail_count++;
			end else begin
				want = results_due.pop_front();
				if (out_byte !== want.out_b) begin
					$display("%0t: out_byte expected %h actual %h", $time, want.out_b, out_byte);
					fail_count++;
				end
				if (crc_value !== want.crc) begin
					$display("%0t: crc_value expected %h actual %h", $time, want.crc, crc_value);
					fail_count++;
				end
				if (crc_match !== want.match) begin
					$display("%0t: crc_match expected %b actual %b", $time, want.match, crc_match);
					fail_count++;
				end
				if (run_last !== want.last) begin
					$display("%0t: run_last expected %b actual %b", $time, want.last, run_last);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin : stall_watch
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("crc16_frame_append_check_top: mismatch");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	initial begin : stimulus
		logic [7:0] body[$];
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// check mode at reset settings: short frame, bare crc, known frame, spoilt frame
		queue_byte(8'h00, 1'b1);
		body.delete();
		queue_frame(body, 1'b1, 1'b0);
		body = '{8'h01, 8'h03, 8'h00, 8'h00, 8'h00, 8'h01};
		queue_frame(body, 1'b1, 1'b0);
		body = '{8'hFF, 8'h80};
		queue_frame(body, 1'b1, 1'b1);
		// frame left open, abandoned by the register write
		queue_byte(8'h5A, 1'b0);
		queue_byte(8'hFF, 1'b0);
		wait_idle();

		// append mode from a zero start value
		write_reg(crc16fac_pkg::REG_START_VALUE, 16'h0000);
		write_reg(crc16fac_pkg::REG_APPEND_MODE,
			{{(crc16fac_pkg::CFG_DATA_W-1){1'b0}}, MODE_APPEND});
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'h00, 1'b1);
		body = '{8'h12, 8'h34, 8'hAB};
		queue_frame(body, 1'b0, 1'b0);
		queue_byte(8'h7E, 1'b0);
		wait_idle();

		// random frames over several settings
		run_phase(16'hFFFF, MODE_CHECK, 32, 1'b1, 1'b0);
		run_phase(16'h0000, MODE_CHECK, 28, 1'b0, 1'b0);
		run_phase(16'($urandom), MODE_APPEND, 24, 1'b0, 1'b1);
		run_phase(16'hFFFF, MODE_APPEND, 24, 1'b0, 1'b0);
		run_phase(16'($urandom), MODE_CHECK, 36, 1'b0, 1'b0);
		run_phase(16'h0000, MODE_APPEND, 24, 1'b0, 1'b0);

		if (fail_count == 0 && results_due.size() == 0) begin
			$display("crc16_frame_append_check_top: match");
		end else begin
			$display("crc16_frame_append_check_top: mismatch");
		end
		$finish;
	end

endmodule
